[src/jia_pkg.sv]
// shared types, operation codes and helpers for the integer alu
// used by jvm_integer_alu and jia_div_step
package jia_pkg;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_REM  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_XOR  = 4'd7;
  localparam logic [3:0] OP_SHL  = 4'd8;
  localparam logic [3:0] OP_SHR  = 4'd9;
  localparam logic [3:0] OP_USHR = 4'd10;

  localparam logic [5:0] LONG_SHIFT_MASK = 6'h3F;
  localparam logic [5:0] INT_SHIFT_MASK  = 6'h1F;

  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
  } div_t;

  typedef struct packed {
    logic [3:0]  action;
    logic        is_long;
    logic        na;
    logic        nb;
    logic        dz;
    logic [63:0] res;
    logic [63:0] pp_lo;
    logic [31:0] pp_h1;
    logic [31:0] pp_h2;
    div_t        dv;
  } stage_t;

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage

[src/jia_div_step.sv]
// one restoring divide step: one quotient bit per instance
// depends on jia_pkg
module jia_div_step (
  input  jia_pkg::div_t din,
  output jia_pkg::div_t dout
);
  import jia_pkg::*;

  logic [64:0] trial;

  assign trial = {din.rem, din.quo[63]} - {1'b0, din.dvs};

  always_comb begin
    dout.dvs = din.dvs;
    if (!trial[64]) begin
      dout.rem = trial[63:0];
      dout.quo = {din.quo[62:0], 1'b1};
    end else begin
      dout.rem = {din.rem[62:0], din.quo[63]};
      dout.quo = {din.quo[62:0], 1'b0};
    end
  end

endmodule

[src/jvm_integer_alu.sv]
// top level of the java-style int/long integer alu
// depends on jia_pkg and jia_div_step
//
// input channel: in_valid, in_stall with action, is_long, operand_a, operand_b.
// output channel: out_valid, out_stall with result and div_by_zero.
// a transfer happens at a rising edge where valid is high and stall is low.
// every operation, not only div and rem, walks the same pipeline: one input
// register, one stage for the shifter, adder and the three 32x32 partial
// products, 64 divider stages (one quotient bit each, the first also sums the
// multiplier partials), and the output register. one operation enters each cycle
// while the output is not stalled. the 64-step restoring divider sets the depth.
// the whole pipeline moves together; when the output holds a result and the
// receiver stalls, every stage freezes and in_stall is raised, so nothing is
// lost or repeated. reset (rst, synchronous) clears all valid bits.
module jvm_integer_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic        is_long,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result,
  output logic        div_by_zero
);
  import jia_pkg::*;

  logic        adv;
  logic        vp;
  logic [3:0]  p_action;
  logic        p_long;
  logic [63:0] pa;
  logic [63:0] pb;

  logic [DIV_STEPS:0] vld;
  stage_t             d [DIV_STEPS+1];
  stage_t             s1_next;

  logic [5:0]  sh;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] q_fix;
  logic [63:0] r_fix;
  logic [63:0] res_next;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input register with sign extension for int mode
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (adv) begin
      vp <= in_valid;
    end
    if (adv) begin
      p_action <= action;
      p_long   <= is_long;
      pa       <= is_long ? operand_a : sext32(operand_a);
      pb       <= is_long ? operand_b : sext32(operand_b);
    end
  end

  // simple operations, multiplier partials and divider setup
  always_comb begin
    sh = pb[5:0] & (p_long ? LONG_SHIFT_MASK : INT_SHIFT_MASK);
    ma = pa[63] ? (64'd0 - pa) : pa;
    mb = pb[63] ? (64'd0 - pb) : pb;
    s1_next.action = p_action;
    s1_next.is_long = p_long;
    s1_next.na = pa[63];
    s1_next.nb = pb[63];
    s1_next.dz = (p_action == OP_DIV || p_action == OP_REM) && (pb == 64'd0);
    case (p_action)
      OP_ADD:  s1_next.res = pa + pb;
      OP_SUB:  s1_next.res = pa - pb;
      OP_AND:  s1_next.res = pa & pb;
      OP_OR:   s1_next.res = pa | pb;
      OP_XOR:  s1_next.res = pa ^ pb;
      OP_SHL:  s1_next.res = pa << sh;
      OP_SHR:  s1_next.res = $unsigned($signed(pa) >>> sh);
      OP_USHR: s1_next.res = p_long ? (pa >> sh) : ({32'd0, pa[31:0]} >> sh);
      default: s1_next.res = 64'd0;
    endcase
    s1_next.pp_lo = {32'd0, pa[31:0]} * {32'd0, pb[31:0]};
    s1_next.pp_h1 = 32'(pa[31:0] * pb[63:32]);
    s1_next.pp_h2 = 32'(pa[63:32] * pb[31:0]);
    s1_next.dv.rem = 64'd0;
    s1_next.dv.quo = ma;
    s1_next.dv.dvs = mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= vp;
    end
    if (adv) begin
      d[0] <= s1_next;
    end
  end

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
      div_t   step_out;
      stage_t nxt;

      jia_div_step u_step (
        .din  (d[k].dv),
        .dout (step_out)
      );

      always_comb begin
        nxt    = d[k];
        nxt.dv = step_out;
        // first divider stage also finishes the multiplier
        if (k == 0 && d[k].action == OP_MUL) begin
          nxt.res = d[k].pp_lo + {d[k].pp_h1 + d[k].pp_h2, 32'd0};
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (adv) begin
          vld[k+1] <= vld[k];
        end
        if (adv) begin
          d[k+1] <= nxt;
        end
      end
    end
  endgenerate

  // sign fix-up, result select and int-mode narrowing
  always_comb begin
    q_fix = (d[DIV_STEPS].na ^ d[DIV_STEPS].nb) ? (64'd0 - d[DIV_STEPS].dv.quo)
                                                : d[DIV_STEPS].dv.quo;
    r_fix = d[DIV_STEPS].na ? (64'd0 - d[DIV_STEPS].dv.rem) : d[DIV_STEPS].dv.rem;
    if (d[DIV_STEPS].dz) begin
      res_next = '1;
    end else if (d[DIV_STEPS].action == OP_DIV) begin
      res_next = q_fix;
    end else if (d[DIV_STEPS].action == OP_REM) begin
      res_next = r_fix;
    end else begin
      res_next = d[DIV_STEPS].res;
    end
    if (!d[DIV_STEPS].is_long) begin
      res_next = sext32(res_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DIV_STEPS];
    end
    if (adv) begin
      result      <= res_next;
      div_by_zero <= d[DIV_STEPS].dz;
    end
  end

  a_dz_all_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_by_zero |-> result == '1)
    else $error("div_by_zero without all-ones result");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vld) && $stable(vp))
    else $error("pipeline moved during output stall");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vp)
    else $error("accepted item not captured");

  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STEPS] && d[DIV_STEPS].dz |->
      d[DIV_STEPS].action == OP_DIV || d[DIV_STEPS].action == OP_REM)
    else $error("zero-divisor flag on non-divide");

endmodule

[tb/jvm_integer_alu_test.sv]
// self-checking testbench for jvm_integer_alu: directed and random int/long operations
// depends on jia_pkg for the operation codes and on the jvm_integer_alu rtl
module jvm_integer_alu_test;
  import jia_pkg::*;

  typedef struct {
    logic [3:0]  action;
    logic        is_long;
    logic [63:0] a;
    logic [63:0] b;
  } alu_op_t;

  typedef struct {
    logic [63:0] value;
    logic        dz;
  } alu_res_t;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN32 = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] ONES  = '1;
  localparam int LATENCY = 67;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPS = 1630;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [3:0]  action = '0;
  logic        is_long = 0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [63:0] result;
  logic        div_by_zero;

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int received = 0;
  int dz_seen = 0;
  bit stim_done = 0;
  bit quiet = 0;
  int in_gap = 0;
  int out_gap = 0;

  jvm_integer_alu u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [63:0] sx32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic alu_res_t compute_alu(alu_op_t op);
    alu_res_t r;
    logic [63:0] a, b, ma, mb, q;
    logic [5:0] sh;
    r.value = '0;
    r.dz = 0;
    a = op.is_long ? op.a : sx32(op.a);
    b = op.is_long ? op.b : sx32(op.b);
    sh = op.is_long ? b[5:0] : {1'b0, b[4:0]};
    case (op.action)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV, OP_REM: begin
        if (b == 0) begin
          r.value = ONES;
          r.dz = 1;
        end else begin
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          if (op.action == OP_REM) begin
            q = ma % mb;
            r.value = a[63] ? -q : q;
          end else begin
            q = ma / mb;
            r.value = (a[63] != b[63]) ? -q : q;
          end
        end
      end
      OP_AND: r.value = a & b;
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_SHL: r.value = a << sh;
      OP_SHR: r.value = $signed(a) >>> sh;
      OP_USHR: r.value = op.is_long ? a >> sh : {32'b0, a[31:0]} >> sh;
      default: r.value = '0;
    endcase
    if (!op.is_long) r.value = sx32(r.value);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, received);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = MIN64;
      1: v = MAX64;
      2: v = ONES;
      3: v = '0;
      4: v = 64'($signed(32'($urandom_range(0, 20)) - 10));
      5: v = $urandom_range(0, 1) ? MIN32 : 64'h7FFF_FFFF;
      6: v = {{32{v[31]}}, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_op(logic [3:0] act, logic lng, logic [63:0] a, logic [63:0] b);
    alu_op_t op;
    op.action = act;
    op.is_long = lng;
    op.a = a;
    op.b = b;
    pending_ops.push_back(op);
  endtask

  initial begin
    logic [3:0] act;
    for (int m = 0; m < 2; m++) begin
      push_op(OP_ADD, 1'(m), MAX64, 64'd1);
      push_op(OP_SUB, 1'(m), MIN64, 64'd1);
      push_op(OP_MUL, 1'(m), MIN64, ONES);
      push_op(OP_DIV, 1'(m), m ? MIN64 : MIN32, ONES);
      push_op(OP_REM, 1'(m), m ? MIN64 : MIN32, ONES);
      push_op(OP_DIV, 1'(m), 64'd7, 64'hFFFF_FFFF_0000_0000);
      push_op(OP_REM, 1'(m), -64'sd7, '0);
      push_op(OP_DIV, 1'(m), -64'sd7, 64'd2);
      push_op(OP_AND, 1'(m), ONES, 64'h1234_5678_9ABC_DEF0);
      push_op(OP_OR, 1'(m), '0, 64'h8000_0001_8000_0001);
      push_op(OP_XOR, 1'(m), ONES, MAX64);
      push_op(OP_SHL, 1'(m), 64'd1, 64'd63);
    end
    push_op(OP_SHR, 1, MIN64, 64'd127);
    push_op(OP_USHR, 0, ONES, 64'd33);
    push_op(4'd15, 1, ONES, ONES);
    for (int i = 0; i < RANDOM_OPS; i++) begin
      act = (i % 16 == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      push_op(act, 1'($urandom_range(0, 1)), rand_operand(), rand_operand());
    end
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= 7) rst <= 0;
    quiet <= pending_ops.size() < 200;
    if (!rst && !(in_valid && in_stall)) begin
      if (in_valid) sent <= sent + 1;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(1, 13);
        in_valid <= 0;
      end else if (pending_ops.size() > 0) begin
        alu_op_t op;
        op = pending_ops.pop_front();
        expected_results.push_back(compute_alu(op));
        in_valid <= 1;
        action <= op.action;
        is_long <= op.is_long;
        operand_a <= op.a;
        operand_b <= op.b;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", result, '0);
        end else begin
          alu_res_t want;
          want = expected_results.pop_front();
          if (result !== want.value) report_mismatch("result", result, want.value);
          if (div_by_zero !== want.dz)
            report_mismatch("div_by_zero", 64'(div_by_zero), 64'(want.dz));
          if (want.dz) dz_seen <= dz_seen + 1;
        end
        received <= received + 1;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(1, 13);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  initial begin
    wait (stim_done && pending_ops.size() == 0 && !in_valid && expected_results.size() == 0
          || cycles >= CYCLE_LIMIT);
    if (cycles < CYCLE_LIMIT) repeat (LATENCY + 10) @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[jvm_integer_alu] ERROR");
    end else begin
      $display("sent %0d and checked %0d int/long operations over all actions, %0d %s",
               sent, received, dz_seen, "divide-by-zero cases");
      if (errors == 0) $display("[jvm_integer_alu] OK");
      else $display("[jvm_integer_alu] ERROR");
    end
    $finish;
  end
endmodule
